// File: rtl/mandelbrot_escape_time_top_macros.svh
// Assertion macros for the escape-time evaluator.
// Needs i_clk and i_rst_n in the scope of use.
`ifndef MANDELBROT_ESCAPE_TIME_TOP_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define MBET_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mbet: same-cycle check failed");

// next-cycle implication, disabled during reset
`define MBET_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mbet: next-cycle check failed");

`endif

// File: rtl/mbet_pkg.sv
// Shared constants, sequencer states and helpers for the escape-time evaluator.
// No dependencies.
package mbet_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 26;
    localparam int WORD_BITS  = 32;
    localparam int CNT_BITS   = 16;
    localparam int OPD_BITS   = WORD_BITS + 1;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int IDX_BITS   = 3;

    localparam logic [PROD_BITS-1:0] ESC_LIMIT = PROD_BITS'(4) << (2 * FRAC_BITS);
    localparam logic [CNT_BITS-1:0]  MAX_IT_RESET = CNT_BITS'(200);

    localparam logic [IDX_BITS-1:0] CFG_LEFT   = IDX_BITS'(0);
    localparam logic [IDX_BITS-1:0] CFG_TOP    = IDX_BITS'(1);
    localparam logic [IDX_BITS-1:0] CFG_XSTEP  = IDX_BITS'(2);
    localparam logic [IDX_BITS-1:0] CFG_YSTEP  = IDX_BITS'(3);
    localparam logic [IDX_BITS-1:0] CFG_MAX_IT = IDX_BITS'(4);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CX,
        S_CY,
        S_CI,
        S_RR,
        S_II,
        S_RI,
        S_UPD,
        S_DONE
    } t_state;

    // saturate a 64-bit value to the signed 32-bit range
    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [PROD_BITS-1:0] v
    );
        logic [PROD_BITS-WORD_BITS:0] top;
        top = v[PROD_BITS-1:WORD_BITS-1];
        if (top == '0 || top == '1) begin
            return v[WORD_BITS-1:0];
        end else if (v[PROD_BITS-1]) begin
            return {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(WORD_BITS-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [PROD_BITS-1:0] sext_word(
        input logic signed [WORD_BITS-1:0] v
    );
        return {{(PROD_BITS-WORD_BITS){v[WORD_BITS-1]}}, v};
    endfunction

endpackage

// File: rtl/mandelbrot_escape_time_top.sv
// Escape-time evaluator top level: config registers, sequencer, shared multiplier.
// Depends on mbet_pkg and mandelbrot_escape_time_top_macros.svh.
//
// One pixel word is taken at a time. After the accepting cycle, states S_CX, S_CY and
// S_CI build the point c. Each iteration of z = z*z + c then runs through S_RR, S_II,
// S_RI and S_UPD on the single 33x33 signed multiplier (zr*zr, zi*zi, zr*zi, then
// update and escape test). S_RR also checks the limit (200 by default), and S_DONE
// hands the word to the output register once that register is free. The input is
// stalled from acceptance until the result is in the output register; a waiting
// result does not block the next pixel.
`include "mandelbrot_escape_time_top_macros.svh"

module mandelbrot_escape_time_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [mbet_pkg::IDX_BITS-1:0]     i_cfg_index,
    input  logic [mbet_pkg::WORD_BITS-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mbet_pkg::COORD_BITS-1:0]   i_pixel_x,
    input  logic [mbet_pkg::COORD_BITS-1:0]   i_pixel_y,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mbet_pkg::COORD_BITS-1:0]   o_out_x,
    output logic [mbet_pkg::COORD_BITS-1:0]   o_out_y,
    output logic [mbet_pkg::CNT_BITS-1:0]     o_iteration_count
);

    localparam int WB = mbet_pkg::WORD_BITS;
    localparam int PB = mbet_pkg::PROD_BITS;
    localparam int OB = mbet_pkg::OPD_BITS;
    localparam int CB = mbet_pkg::COORD_BITS;
    localparam int NB = mbet_pkg::CNT_BITS;
    localparam int FB = mbet_pkg::FRAC_BITS;

    mbet_pkg::t_state r_state, n_state;

    logic signed [WB-1:0] r_left, r_top, r_xstep, r_ystep;
    logic [NB-1:0]        r_max_it;

    logic [CB-1:0]        r_px, r_py;
    logic signed [WB-1:0] r_cr, r_ci, r_zr, r_zi;
    logic [NB-1:0]        r_count;
    logic signed [PB-1:0] r_prod, r_diff;
    logic [PB-1:0]        r_rr;
    logic                 r_esc;

    logic                 r_out_valid;
    logic [CB-1:0]        r_out_x, r_out_y;
    logic [NB-1:0]        r_out_cnt;

    logic signed [OB-1:0]   mul_a, mul_b;
    logic signed [2*OB-1:0] mul_p;
    logic                   in_take, out_take, out_load, slot_free;
    logic signed [PB-1:0]   nr, ni;
    logic                   st_done;

    assign in_take   = i_in_valid && (r_state == mbet_pkg::S_IDLE);
    assign out_take  = r_out_valid && !i_out_stall;
    assign slot_free = !r_out_valid || !i_out_stall;
    assign mul_p     = mul_a * mul_b;
    assign st_done   = (r_state == mbet_pkg::S_DONE);

    assign nr = (r_diff >>> FB) + mbet_pkg::sext_word(r_cr);
    assign ni = (r_prod >>> (FB - 1)) + mbet_pkg::sext_word(r_ci);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbet_pkg::S_IDLE: if (i_in_valid) n_state = mbet_pkg::S_CX;
            mbet_pkg::S_CX:   n_state = mbet_pkg::S_CY;
            mbet_pkg::S_CY:   n_state = mbet_pkg::S_CI;
            mbet_pkg::S_CI:   n_state = mbet_pkg::S_RR;
            mbet_pkg::S_RR: begin
                if (r_count >= r_max_it) n_state = mbet_pkg::S_DONE;
                else n_state = mbet_pkg::S_II;
            end
            mbet_pkg::S_II:   n_state = mbet_pkg::S_RI;
            mbet_pkg::S_RI:   n_state = mbet_pkg::S_UPD;
            mbet_pkg::S_UPD: begin
                if (r_esc) n_state = mbet_pkg::S_DONE;
                else n_state = mbet_pkg::S_RR;
            end
            mbet_pkg::S_DONE: if (slot_free) n_state = mbet_pkg::S_IDLE;
            default:          n_state = mbet_pkg::S_IDLE;
        endcase
    end

    // multiplier operand select and output load
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        out_load = 1'b0;
        unique case (r_state)
            mbet_pkg::S_CX: begin
                mul_a = $signed({{(OB-CB){1'b0}}, r_px});
                mul_b = {r_xstep[WB-1], r_xstep};
            end
            mbet_pkg::S_CY: begin
                mul_a = $signed({{(OB-CB){1'b0}}, r_py});
                mul_b = {r_ystep[WB-1], r_ystep};
            end
            mbet_pkg::S_RR: begin
                mul_a = {r_zr[WB-1], r_zr};
                mul_b = {r_zr[WB-1], r_zr};
            end
            mbet_pkg::S_II: begin
                mul_a = {r_zi[WB-1], r_zi};
                mul_b = {r_zi[WB-1], r_zi};
            end
            mbet_pkg::S_RI: begin
                mul_a = {r_zr[WB-1], r_zr};
                mul_b = {r_zi[WB-1], r_zi};
            end
            mbet_pkg::S_DONE: out_load = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbet_pkg::S_IDLE;
            r_left      <= '0;
            r_top       <= '0;
            r_xstep     <= '0;
            r_ystep     <= '0;
            r_max_it    <= mbet_pkg::MAX_IT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    mbet_pkg::CFG_LEFT:   r_left   <= i_cfg_data;
                    mbet_pkg::CFG_TOP:    r_top    <= i_cfg_data;
                    mbet_pkg::CFG_XSTEP:  r_xstep  <= i_cfg_data;
                    mbet_pkg::CFG_YSTEP:  r_ystep  <= i_cfg_data;
                    mbet_pkg::CFG_MAX_IT: r_max_it <= i_cfg_data[NB-1:0];
                    default: ;
                endcase
            end
            if (out_load) r_out_valid <= 1'b1;
            else if (out_take) r_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[PB-1:0];
        if (in_take) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        unique case (r_state)
            mbet_pkg::S_CY: r_cr <= mbet_pkg::sat_word(r_prod + mbet_pkg::sext_word(r_left));
            mbet_pkg::S_CI: begin
                r_ci    <= mbet_pkg::sat_word(r_prod + mbet_pkg::sext_word(r_top));
                r_zr    <= '0;
                r_zi    <= '0;
                r_count <= '0;
            end
            mbet_pkg::S_II: r_rr <= r_prod;
            mbet_pkg::S_RI: begin
                r_diff <= $signed(r_rr) - r_prod;
                r_esc  <= (r_rr + $unsigned(r_prod)) >= mbet_pkg::ESC_LIMIT;
            end
            mbet_pkg::S_UPD: begin
                if (!r_esc) begin
                    r_zr    <= mbet_pkg::sat_word(nr);
                    r_zi    <= mbet_pkg::sat_word(ni);
                    r_count <= r_count + NB'(1);
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_x   <= r_px;
            r_out_y   <= r_py;
            r_out_cnt <= r_count;
        end
    end

    assign o_in_stall        = (r_state != mbet_pkg::S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_out_x           = r_out_x;
    assign o_out_y           = r_out_y;
    assign o_iteration_count = r_out_cnt;

    `MBET_ASSERT_NOW(a_count_below_limit, r_state == mbet_pkg::S_UPD, r_count < r_max_it)
    `MBET_ASSERT_NEXT(a_done_waits_for_slot, st_done && r_out_valid && i_out_stall, st_done)
    `MBET_ASSERT_NEXT(a_accept_starts_work, i_in_valid && !o_in_stall, (r_state == mbet_pkg::S_CX) && o_in_stall)

endmodule

// File: tb/tb.sv
// Testbench for mandelbrot_escape_time_top: feeds pixel words with random gaps and
// output stalls, predicts each escape count in Q6.26 and checks every result word.
// Depends on mbet_pkg and the RTL top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS  = mbet_pkg::FRAC_BITS;
    localparam int COORD_BITS = mbet_pkg::COORD_BITS;
    localparam int CNT_BITS   = mbet_pkg::CNT_BITS;
    localparam int PROD_BITS  = mbet_pkg::PROD_BITS;
    localparam int IDX_BITS   = mbet_pkg::IDX_BITS;
    localparam int WORD_BITS  = mbet_pkg::WORD_BITS;
    localparam logic [CNT_BITS-1:0] MAX_IT_RESET = mbet_pkg::MAX_IT_RESET;
    localparam logic [IDX_BITS-1:0] CFG_LEFT     = mbet_pkg::CFG_LEFT;
    localparam logic [IDX_BITS-1:0] CFG_TOP      = mbet_pkg::CFG_TOP;
    localparam logic [IDX_BITS-1:0] CFG_XSTEP    = mbet_pkg::CFG_XSTEP;
    localparam logic [IDX_BITS-1:0] CFG_YSTEP    = mbet_pkg::CFG_YSTEP;
    localparam logic [IDX_BITS-1:0] CFG_MAX_IT   = mbet_pkg::CFG_MAX_IT;

    localparam int CLK_PERIOD    = 10;
    localparam int ONE           = 1 << FRAC_BITS;
    localparam int Q_MAX         = 32'sh7FFF_FFFF;
    localparam int Q_MIN         = 32'sh8000_0000;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int HALF_SPAN     = 1 << (COORD_BITS - 1);
    localparam int MAX_GAP       = 5;
    localparam int NUM_VIEWS     = 10;
    localparam int VIEW_PIXELS   = 130;
    localparam int PRESSURE_VIEW = 2;
    localparam int DEEP_VIEW     = 4;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    // worst case is every pixel at its limit plus gaps, stalls and one
    // 65535-iteration point; this is several times that
    localparam int CYCLE_LIMIT   = 6_000_000;
    localparam logic [CNT_BITS-1:0] LIMIT_MAX = '1;
    localparam logic [PROD_BITS-1:0] ESCAPE_BOUND = 64'd4 << (2 * FRAC_BITS);

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [CNT_BITS-1:0]   count;
    } t_escape;

    class escape_scoreboard;
        int                  left_edge  = 0;
        int                  top_edge   = 0;
        int                  x_step     = 0;
        int                  y_step     = 0;
        logic [CNT_BITS-1:0] iter_limit = MAX_IT_RESET;
        t_escape             pending[$];
        int                  errors     = 0;
        int                  checked    = 0;
        int                  limit_hits = 0;

        function void set_reg(logic [IDX_BITS-1:0] idx, logic [WORD_BITS-1:0] val);
            case (idx)
                CFG_LEFT:   left_edge  = int'(val);
                CFG_TOP:    top_edge   = int'(val);
                CFG_XSTEP:  x_step     = int'(val);
                CFG_YSTEP:  y_step     = int'(val);
                CFG_MAX_IT: iter_limit = val[CNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_word(longint v);
            if (v > longint'(Q_MAX)) return longint'(Q_MAX);
            if (v < longint'(Q_MIN)) return longint'(Q_MIN);
            return v;
        endfunction

        function int escape_count(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
            longint          cr, ci, zr, zi, nr, ni;
            longint unsigned rr, ii;
            int              n;
            cr = clamp_word(longint'(px) * x_step + left_edge);
            ci = clamp_word(longint'(py) * y_step + top_edge);
            zr = 0;
            zi = 0;
            n  = 0;
            while (n < iter_limit) begin
                rr = zr * zr;
                ii = zi * zi;
                if (rr + ii >= ESCAPE_BOUND) break;
                nr = ((longint'(rr) - longint'(ii)) >>> FRAC_BITS) + cr;
                ni = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
                zr = clamp_word(nr);
                zi = clamp_word(ni);
                n++;
            end
            return n;
        endfunction

        function void note_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
            t_escape e;
            e.x     = x;
            e.y     = y;
            e.count = CNT_BITS'(escape_count(x, y));
            if (e.count == iter_limit) limit_hits++;
            pending.insert(pending.size(), e);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 50) $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                          input logic [CNT_BITS-1:0] count);
            t_escape e;
            checked++;
            if (pending.size() == 0) begin
                report($sformatf("word (%0d,%0d) count %0d with nothing pending",
                                 x, y, count));
                return;
            end
            e = pending.pop_front();
            if (x !== e.x) report($sformatf("x %0d, predicted %0d", x, e.x));
            if (y !== e.y) report($sformatf("y %0d, predicted %0d", y, e.y));
            if (count !== e.count)
                report($sformatf("pixel (%0d,%0d) count %0d, predicted %0d",
                                 e.x, e.y, count, e.count));
        endtask
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [IDX_BITS-1:0]   i_cfg_index = CFG_LEFT;
    logic [WORD_BITS-1:0]  i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [COORD_BITS-1:0] i_pixel_x   = '0;
    logic [COORD_BITS-1:0] i_pixel_y   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [COORD_BITS-1:0] o_out_x;
    logic [COORD_BITS-1:0] o_out_y;
    logic [CNT_BITS-1:0]   o_iteration_count;

    escape_scoreboard sb;
    logic             steady    = 1'b0;
    logic             hold_req  = 1'b0;
    logic             hold_off  = 1'b0;
    int unsigned      sink_wait = 0;
    int               pixels_sent = 0;
    int               views_done  = 0;

    mandelbrot_escape_time_top i_dut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic cfg_word(input logic [IDX_BITS-1:0] idx, input logic [WORD_BITS-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // all five registers, then a write to an unused index that must change nothing
    task automatic set_view(input int left, input int top, input int xs, input int ys,
                            input logic [CNT_BITS-1:0] lim);
        logic [IDX_BITS-1:0] spare;
        spare = IDX_BITS'($urandom_range(CFG_MAX_IT + 1, (1 << IDX_BITS) - 1));
        cfg_word(CFG_LEFT, left);
        cfg_word(CFG_TOP, top);
        cfg_word(CFG_XSTEP, xs);
        cfg_word(CFG_YSTEP, ys);
        cfg_word(CFG_MAX_IT, WORD_BITS'(lim) | ($urandom << CNT_BITS));
        cfg_word(spare, $urandom);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_view(input int v);
        int                  xs, ys, cx, cy;
        logic [CNT_BITS-1:0] lim;
        if (v == DEEP_VIEW)   lim = CNT_BITS'(255);
        else if (v == 0)      lim = CNT_BITS'(1);
        else                  lim = CNT_BITS'($urandom_range(1, 48));
        if (v % 3 == 2) begin
            set_view($urandom, $urandom, $urandom, $urandom,
                     CNT_BITS'($urandom_range(0, 24)));
        end else begin
            xs = int'($urandom_range(ONE >> 12, ONE >> 8));
            ys = int'($urandom_range(ONE >> 12, ONE >> 8));
            if ($urandom_range(0, 1)) xs = -xs;
            if ($urandom_range(0, 1)) ys = -ys;
            cx = -3 * ONE / 2 + int'($urandom_range(0, 7 * ONE / 4));
            cy = -ONE + int'($urandom_range(0, 2 * ONE));
            set_view(cx - HALF_SPAN * xs, cy - HALF_SPAN * ys, xs, ys, lim);
        end
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_x  <= x;
        i_pixel_y  <= y;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pixel(x, y);
        pixels_sent++;
    endtask

    task automatic idle_wait();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_sink
        int unsigned wait_left;
        wait_left = sink_wait;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_x, o_out_y, o_iteration_count);
            wait_left = steady ? 0 : $urandom_range(0, MAX_GAP);
        end else if (wait_left != 0) begin
            wait_left--;
        end
        sink_wait   <= wait_left;
        i_out_stall <= hold_off || (wait_left != 0);
    end

    // output side stops for a long stretch so the block backs up into its input
    initial begin : long_hold
        wait (hold_req);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d words outstanding",
                 CYCLE_LIMIT, sb.pending.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset view: c = 0 everywhere, every pixel runs to the default limit
        send_pixel(0, 0);
        send_pixel(COORD_MAX, COORD_MAX);
        i_in_valid <= 1'b0;
        idle_wait();

        // classic view, corners, centre and alternating bit patterns
        set_view(-2 * ONE, -3 * ONE / 2, 3 * (ONE >> 10), 3 * (ONE >> 10), 64);
        send_pixel(0, 0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(0, COORD_MAX);
        send_pixel(COORD_MAX, 0);
        send_pixel(HALF_SPAN, HALF_SPAN);
        send_pixel(10'h2AA, 10'h155);
        send_pixel(10'h155, 10'h2AA);
        send_pixel(683, HALF_SPAN);
        i_in_valid <= 1'b0;
        idle_wait();

        // zero limit
        set_view(-2 * ONE, -3 * ONE / 2, 3 * (ONE >> 10), 3 * (ONE >> 10), 0);
        send_pixel(5, 7);
        send_pixel(COORD_MAX, 0);
        i_in_valid <= 1'b0;
        idle_wait();

        // c saturates high and low
        set_view(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 3);
        send_pixel(0, 0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(1, 1);
        i_in_valid <= 1'b0;
        idle_wait();
        set_view(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 3);
        send_pixel(COORD_MAX, COORD_MAX);
        i_in_valid <= 1'b0;
        idle_wait();

        // |z|^2 landing exactly on 4, and points on the real axis
        set_view(2 * ONE, 0, -(ONE >> 2), 0, 10);
        send_pixel(0, 0);
        send_pixel(2, 0);
        send_pixel(8, 0);
        send_pixel(9, 0);
        i_in_valid <= 1'b0;
        idle_wait();

        // largest limit: one point never escapes, one escapes after a single iteration
        set_view(0, 0, ONE >> 4, ONE >> 4, LIMIT_MAX);
        send_pixel(0, 0);
        send_pixel(40, 0);
        i_in_valid <= 1'b0;

        for (int v = 0; v < NUM_VIEWS; v++) begin
            steady <= (v % 4 == 1) || (v == PRESSURE_VIEW);
            idle_wait();
            random_view(v);
            if (v == PRESSURE_VIEW) hold_req <= 1'b1;
            repeat (VIEW_PIXELS) send_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom));
            i_in_valid <= 1'b0;
            views_done++;
        end

        idle_wait();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d result words for %0d pixels: directed views plus %0d random ones.",
                 sb.checked, pixels_sent, views_done);
        $display("%0d pixels ran to their iteration limit; %0d mismatches.",
                 sb.limit_hits, sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
